// ----- design/flow_fairness_window_throttle_assert.svh -----
// Assertion macros for the checker file of the flow fairness window throttle.
`ifndef FLOW_FAIRNESS_WINDOW_THROTTLE_ASSERT_SVH
`define FLOW_FAIRNESS_WINDOW_THROTTLE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define FWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/fwt_pkg.sv -----
// Shared types and constants of the flow fairness window throttle.
package fwt_pkg;

	localparam int ID_W       = 16;
	localparam int CNT_W      = 32;
	localparam int WIN_W      = 16;
	localparam int CLS_W      = 16;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// event commands
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMB_THRESH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_MARGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_WIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_WIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_FLOWS   = 3'd4;

	// register reset values
	localparam logic [CNT_W-1:0] RST_IMB_THRESH  = 32'd4096;
	localparam logic [CNT_W-1:0] RST_NEAR_MARGIN = 32'd2048;
	localparam logic [WIN_W-1:0] RST_THR_WIN     = 16'd6000;
	localparam logic [WIN_W-1:0] RST_FULL_WIN    = 16'd65535;
	localparam logic [CLS_W-1:0] RST_EXP_FLOWS   = 16'd0;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CLS_W-1:0] CLS_MAX = '1;

	typedef struct packed {
		logic [CNT_W-1:0] imb_thresh;
		logic [CNT_W-1:0] near_margin;
		logic [WIN_W-1:0] thr_win;
		logic [WIN_W-1:0] full_win;
		logic [CLS_W-1:0] exp_flows;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_UPDATE,
		ST_MERGE,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic capture;
		logic sweep_rd;
		logic update;
		logic merge;
		logic emit;
	} dp_ctl_t;

	typedef struct packed {
		logic last_addr;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- design/fwt_cfg.sv -----
// Configuration register file with write decode.
module fwt_cfg import fwt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.imb_thresh  <= RST_IMB_THRESH;
			cfg_q.near_margin <= RST_NEAR_MARGIN;
			cfg_q.thr_win     <= RST_THR_WIN;
			cfg_q.full_win    <= RST_FULL_WIN;
			cfg_q.exp_flows   <= RST_EXP_FLOWS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMB_THRESH:  cfg_q.imb_thresh  <= cfg_data[CNT_W-1:0];
				REG_NEAR_MARGIN: cfg_q.near_margin <= cfg_data[CNT_W-1:0];
				REG_THR_WIN:     cfg_q.thr_win     <= cfg_data[WIN_W-1:0];
				REG_FULL_WIN:    cfg_q.full_win    <= cfg_data[WIN_W-1:0];
				REG_EXP_FLOWS:   cfg_q.exp_flows   <= cfg_data[CLS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/fwt_ctrl.sv -----
// Sequencing state machine: table sweep, update, min/max merge and result emit.
module fwt_ctrl import fwt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	input  logic [CMD_W-1:0] cmd,
	input  dp_sts_t          sts,
	output logic             evt_stall,
	output dp_ctl_t          ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		evt_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				evt_stall = 1'b0;
				if (evt_valid) begin
					ctl.capture = 1'b1;
					// only data and close events need the table scan
					if (cmd == CMD_DATA || cmd == CMD_CLOSE) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_UPDATE;
					end
				end
			end
			ST_SWEEP: begin
				ctl.sweep_rd = 1'b1;
				if (sts.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				ctl.update = 1'b1;
				state_d    = ST_MERGE;
			end
			ST_MERGE: begin
				ctl.merge = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/fwt_dp.sv -----
// Datapath: flow table memory, sweep accumulators, close counter and result register.
module fwt_dp import fwt_pkg::*; #(
	parameter int MAX_FLOWS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CMD_W-1:0] cmd,
	input  logic [ID_W-1:0]  flow_id,
	input  logic [CNT_W-1:0] byte_count,
	input  cfg_t             cfg,
	input  dp_ctl_t          ctl,
	output dp_sts_t          sts,
	input  logic             res_stall,
	output logic             res_valid,
	output logic             window_valid,
	output logic [WIN_W-1:0] window_limit,
	output logic             round_done,
	output logic             table_full
);

	localparam int AW = $clog2(MAX_FLOWS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FLOWS - 1);

	// captured event
	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] bytes_q;

	// flow table: valid bits in flops, flow id and count in memory
	logic [MAX_FLOWS-1:0]     valid_q;
	logic [ID_W+CNT_W-1:0]    ent_mem_q [MAX_FLOWS];

	logic [AW-1:0]    addr_q;
	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;
	logic             rd_ent_vld_s1;
	logic [ID_W-1:0]  rd_flow_s1;
	logic [CNT_W-1:0] rd_bytes_s1;

	// sweep results
	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	logic [CNT_W-1:0] hit_bytes_q;
	logic             free_q;
	logic [AW-1:0]    free_idx_q;
	logic [CNT_W-1:0] mn_q;
	logic [CNT_W-1:0] mx_q;
	logic [CNT_W-1:0] newval_q;

	logic [CLS_W-1:0] closes_q;

	logic             res_valid_q;
	logic             window_valid_q;
	logic [WIN_W-1:0] window_limit_q;
	logic             round_done_q;
	logic             table_full_q;

	logic             rd_hit_w;
	logic [CNT_W:0]   sum_w;
	logic [CNT_W-1:0] newval_w;
	logic [AW-1:0]    slot_w;
	logic             slot_ok_w;
	logic [CNT_W-1:0] spread_w;
	logic [CNT_W-1:0] gap_w;
	logic             wv_w;
	logic [WIN_W-1:0] lim_w;
	logic             done_w;
	logic             full_w;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd;
			id_q    <= flow_id;
			bytes_q <= byte_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.sweep_rd;
			if (ctl.capture) begin
				addr_q <= '0;
			end else if (ctl.sweep_rd) begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	// registered table read, one entry a cycle
	always_ff @(posedge clk) begin
		if (ctl.sweep_rd) begin
			rd_idx_s1                 <= addr_q;
			rd_ent_vld_s1             <= valid_q[addr_q];
			{rd_flow_s1, rd_bytes_s1} <= ent_mem_q[addr_q];
		end
		if (ctl.update && cmd_q == CMD_DATA && slot_ok_w) begin
			ent_mem_q[slot_w] <= {id_q, newval_w};
		end
	end

	assign rd_hit_w = rd_vld_s1 && rd_ent_vld_s1 && rd_flow_s1 == id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_hit_w) begin
				hit_q <= 1'b1;
			end
			if (!rd_ent_vld_s1) begin
				free_q <= 1'b1;
			end
		end
	end

	// min/max skip the event's own entry; its new count is merged afterwards
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			mn_q <= CNT_MAX;
			mx_q <= '0;
		end else if (rd_vld_s1) begin
			if (rd_hit_w) begin
				hit_idx_q   <= rd_idx_s1;
				hit_bytes_q <= rd_bytes_s1;
			end else if (rd_ent_vld_s1) begin
				if (rd_bytes_s1 < mn_q) begin
					mn_q <= rd_bytes_s1;
				end
				if (rd_bytes_s1 > mx_q) begin
					mx_q <= rd_bytes_s1;
				end
			end else if (!free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end else if (ctl.merge) begin
			if (newval_q < mn_q) begin
				mn_q <= newval_q;
			end
			if (newval_q > mx_q) begin
				mx_q <= newval_q;
			end
		end
		if (ctl.update) begin
			newval_q <= newval_w;
		end
	end

	assign sum_w     = {1'b0, hit_bytes_q} + {1'b0, bytes_q};
	assign newval_w  = !hit_q ? bytes_q : (sum_w[CNT_W] ? CNT_MAX : sum_w[CNT_W-1:0]);
	assign slot_w    = hit_q ? hit_idx_q : free_idx_q;
	assign slot_ok_w = hit_q || free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			closes_q <= '0;
		end else if (ctl.update) begin
			case (cmd_q)
				CMD_DATA: begin
					if (slot_ok_w) begin
						valid_q[slot_w] <= 1'b1;
					end
				end
				CMD_CLOSE: begin
					if (hit_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
					if (closes_q != CLS_MAX) begin
						closes_q <= closes_q + CLS_W'(1);
					end
				end
				CMD_START: begin
					closes_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign spread_w = mx_q - mn_q;
	assign gap_w    = mx_q - newval_q;

	always_comb begin
		wv_w   = 1'b0;
		lim_w  = '0;
		done_w = 1'b0;
		full_w = 1'b0;
		case (cmd_q)
			CMD_DATA: begin
				wv_w = 1'b1;
				if (!slot_ok_w) begin
					full_w = 1'b1;
					lim_w  = cfg.full_win;
				end else if (spread_w >= cfg.imb_thresh && gap_w <= cfg.near_margin) begin
					lim_w = cfg.thr_win;
				end else begin
					lim_w = cfg.full_win;
				end
			end
			CMD_CLOSE: begin
				done_w = closes_q == cfg.exp_flows;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			window_valid_q <= wv_w;
			window_limit_q <= lim_w;
			round_done_q   <= done_w;
			table_full_q   <= full_w;
		end
	end

	assign sts.last_addr = addr_q == LAST_ADDR;
	assign sts.out_free  = !res_valid_q || !res_stall;

	assign res_valid    = res_valid_q;
	assign window_valid = window_valid_q;
	assign window_limit = window_limit_q;
	assign round_done   = round_done_q;
	assign table_full   = table_full_q;

endmodule

// ----- design/flow_fairness_window_throttle.sv -----
// Top level of the flow fairness window throttle.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  event    | evt_valid, evt_stall | cmd, flow_id, byte_count
//  result   | res_valid, res_stall | window_valid, window_limit, round_done, table_full
//  config   | cfg_we               | cfg_index, cfg_data
//
// Data and close beats pass through the sweep, drain, update, merge and decide states before the
// next accept: the flow table is scanned one entry a cycle through its single registered read port.
// Start and unused commands skip the sweep and drain and go through update, merge and decide.
// Reset clears the table valid bits and close count at once; no clearing pass.
// A stalled result holds in the output register while the next event beat is taken.
module flow_fairness_window_throttle import fwt_pkg::*; #(
	parameter int MAX_FLOWS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  evt_valid,
	output logic                  evt_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [ID_W-1:0]       flow_id,
	input  logic [CNT_W-1:0]      byte_count,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  window_valid,
	output logic [WIN_W-1:0]      window_limit,
	output logic                  round_done,
	output logic                  table_full
);

	cfg_t    cfg;
	dp_ctl_t ctl;
	dp_sts_t sts;

	fwt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.cmd       (cmd),
		.sts       (sts),
		.evt_stall (evt_stall),
		.ctl       (ctl)
	);

	fwt_dp #(
		.MAX_FLOWS (MAX_FLOWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flow_id      (flow_id),
		.byte_count   (byte_count),
		.cfg          (cfg),
		.ctl          (ctl),
		.sts          (sts),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.window_valid (window_valid),
		.window_limit (window_limit),
		.round_done   (round_done),
		.table_full   (table_full)
	);

endmodule

// ----- design/fwt_checker.sv -----
// Port-level checks for the flow fairness window throttle and their bind.
`include "flow_fairness_window_throttle_assert.svh"

module fwt_checker import fwt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  evt_valid,
	input logic                  evt_stall,
	input logic                  res_valid,
	input logic                  res_stall,
	input logic                  window_valid,
	input logic [WIN_W-1:0]      window_limit,
	input logic                  round_done,
	input logic                  table_full
);

	// a stalled result beat stays put
	`FWT_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
		res_valid && $stable({window_valid, window_limit, round_done, table_full}),
		"result changed under stall")

	// one event in flight at a time
	`FWT_ASSERT_NEXT(a_one_item, evt_valid && !evt_stall, evt_stall, "event taken while busy")

	// no result can appear the cycle after an accept
	`FWT_ASSERT_NEXT(a_min_latency, evt_valid && !evt_stall, !$rose(res_valid),
		"result too early")

	`FWT_ASSERT(a_nondata_fields,
		res_valid && !window_valid |-> window_limit == '0 && !table_full,
		"window fields set on non-data result")

	`FWT_ASSERT(a_data_no_done, res_valid && window_valid |-> !round_done,
		"round done on data result")

endmodule

bind flow_fairness_window_throttle fwt_checker u_fwt_checker (.*);

// ----- tb/sv/flow_fairness_window_throttle_tb.sv -----
// Self-checking testbench for the flow fairness window throttle against a flow-table predictor.
module flow_fairness_window_throttle_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fwt_pkg::*;

	localparam int MAX_FLOWS = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = MAX_FLOWS + 10;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BEATS = 160;

	typedef struct packed {
		logic             window_valid;
		logic [WIN_W-1:0] window_limit;
		logic             round_done;
		logic             table_full;
	} decision_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  evt_valid = 1'b0;
	logic                  evt_stall;
	logic [CMD_W-1:0]      cmd = CMD_DATA;
	logic [ID_W-1:0]       flow_id = '0;
	logic [CNT_W-1:0]      byte_count = '0;
	logic                  res_valid;
	logic                  res_stall;
	logic                  window_valid;
	logic [WIN_W-1:0]      window_limit;
	logic                  round_done;
	logic                  table_full;

	// predictor copy of the block state
	cfg_t             cfg_m;
	bit               tbl_live [MAX_FLOWS];
	logic [ID_W-1:0]  tbl_flow [MAX_FLOWS];
	logic [CNT_W-1:0] tbl_bytes [MAX_FLOWS];
	logic [CLS_W-1:0] closes_m;

	decision_t        pending_decisions [$];
	logic [ID_W-1:0]  flow_pool [POOL_SIZE];
	int               mismatches = 0;

	logic             rand_stall = 1'b0;
	int               stall_left = 0;
	logic             hold_req = 1'b0;
	logic             hold_taken = 1'b0;
	int               hold_left = 0;

	assign res_stall = rand_stall || (hold_left != 0);

	flow_fairness_window_throttle #(
		.MAX_FLOWS(MAX_FLOWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.cmd(cmd),
		.flow_id(flow_id),
		.byte_count(byte_count),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.window_valid(window_valid),
		.window_limit(window_limit),
		.round_done(round_done),
		.table_full(table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int find_live(logic [ID_W-1:0] id);
		int i;
		for (i = 0; i < MAX_FLOWS; i++)
			if (tbl_live[i] && tbl_flow[i] == id)
				return i;
		return -1;
	endfunction

	function automatic decision_t throttle_decide(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
			logic [CNT_W-1:0] nb);
		decision_t d;
		int slot;
		int i;
		logic [CNT_W:0] sum;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		d = '0;
		slot = find_live(id);
		case (c)
		CMD_DATA: begin
			d.window_valid = 1'b1;
			if (slot < 0) begin
				// new flow goes to the lowest free slot
				for (i = 0; i < MAX_FLOWS && slot < 0; i++)
					if (!tbl_live[i])
						slot = i;
				if (slot >= 0) begin
					tbl_live[slot] = 1'b1;
					tbl_flow[slot] = id;
					tbl_bytes[slot] = nb;
				end
			end else begin
				sum = {1'b0, tbl_bytes[slot]} + nb;
				tbl_bytes[slot] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
			end
			if (slot < 0) begin
				d.table_full = 1'b1;
				d.window_limit = cfg_m.full_win;
			end else begin
				lo = CNT_MAX;
				hi = '0;
				for (i = 0; i < MAX_FLOWS; i++)
					if (tbl_live[i]) begin
						if (tbl_bytes[i] < lo)
							lo = tbl_bytes[i];
						if (tbl_bytes[i] > hi)
							hi = tbl_bytes[i];
					end
				if (((hi - lo) >= cfg_m.imb_thresh) &&
						((hi - tbl_bytes[slot]) <= cfg_m.near_margin))
					d.window_limit = cfg_m.thr_win;
				else
					d.window_limit = cfg_m.full_win;
			end
		end
		CMD_CLOSE: begin
			if (closes_m != CLS_MAX)
				closes_m++;
			if (slot >= 0)
				tbl_live[slot] = 1'b0;
			if (closes_m == cfg_m.exp_flows)
				d.round_done = 1'b1;
		end
		CMD_START: begin
			closes_m = '0;
		end
		default: ;
		endcase
		return d;
	endfunction

	// half the time a pool flow, else a live table entry when there is one
	function automatic logic [ID_W-1:0] pick_close_target();
		int i;
		int first;
		if ($urandom_range(0, 1) == 0)
			return flow_pool[$urandom_range(0, POOL_SIZE - 1)];
		first = $urandom_range(0, MAX_FLOWS - 1);
		for (i = 0; i < MAX_FLOWS; i++)
			if (tbl_live[(first + i) % MAX_FLOWS])
				return tbl_flow[(first + i) % MAX_FLOWS];
		return ID_W'($urandom);
	endfunction

	task automatic send_event(logic [CMD_W-1:0] c, logic [ID_W-1:0] id, logic [CNT_W-1:0] nb);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		cmd <= c;
		flow_id <= id;
		byte_count <= nb;
		do @(posedge clk); while (evt_stall);
		pending_decisions.insert(pending_decisions.size(), throttle_decide(c, id, nb));
	endtask

	task automatic wait_drained();
		evt_valid <= 1'b0;
		do @(posedge clk); while (pending_decisions.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle; window and expected-flow registers get junk in the upper bits
	task automatic apply_config(logic [CNT_W-1:0] thresh, logic [CNT_W-1:0] margin,
			logic [WIN_W-1:0] thr_win, logic [WIN_W-1:0] full_win, logic [CLS_W-1:0] flows);
		cfg_m.imb_thresh = thresh;
		cfg_m.near_margin = margin;
		cfg_m.thr_win = thr_win;
		cfg_m.full_win = full_win;
		cfg_m.exp_flows = flows;
		cfg_we <= 1'b1;
		cfg_index <= REG_IMB_THRESH;
		cfg_data <= thresh;
		@(posedge clk);
		cfg_index <= REG_NEAR_MARGIN;
		cfg_data <= margin;
		@(posedge clk);
		cfg_index <= REG_THR_WIN;
		cfg_data <= {WIN_W'($urandom), thr_win};
		@(posedge clk);
		cfg_index <= REG_FULL_WIN;
		cfg_data <= {WIN_W'($urandom), full_win};
		@(posedge clk);
		cfg_index <= REG_EXP_FLOWS;
		cfg_data <= {WIN_W'($urandom), flows};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		// reset settings
		send_event(CMD_DATA, 16'h0000, 32'h0000_0000);
		send_event(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF);
		send_event(CMD_DATA, 16'hFFFF, 32'h0000_0005);    // count saturates
		send_event(CMD_DATA, 16'h0000, 32'd100);
		send_event(CMD_DATA, 16'h5A5A, 32'hFFFF_F000);    // near the max
		send_event(CMD_UNUSED, 16'h1234, 32'hDEAD_BEEF);
		send_event(CMD_CLOSE, 16'h7777, 32'h0000_0001);   // unknown flow still counted
		send_event(CMD_START, 16'hAAAA, 32'h5555_5555);
		wait_drained();
		apply_config(32'd0, 32'd0, 16'h0000, 16'h0001, 16'd2);
		send_event(CMD_DATA, 16'h0000, 32'd0);
		send_event(CMD_DATA, 16'h5A5A, 32'd1);
		send_event(CMD_CLOSE, 16'h0000, '0);
		send_event(CMD_CLOSE, 16'h5A5A, '0);              // second close completes the round
		send_event(CMD_CLOSE, 16'hFFFF, '0);
		send_event(CMD_START, 16'h0F0F, '0);
		wait_drained();
		apply_config(CNT_MAX, CNT_MAX, 16'hFFFF, 16'h0000, CLS_MAX);
		send_event(CMD_DATA, 16'h0001, 32'hFFFF_FFFF);
		send_event(CMD_DATA, 16'h0002, 32'h0000_0000);
		send_event(CMD_DATA, 16'h0002, 32'h0000_0001);
		send_event(CMD_CLOSE, 16'h0001, '0);
		send_event(CMD_CLOSE, 16'h0002, '0);
		wait_drained();
	endtask

	task automatic test_table_full();
		logic [ID_W-1:0] live_ids [$];
		int i;
		apply_config(RST_IMB_THRESH, RST_NEAR_MARGIN, RST_THR_WIN, RST_FULL_WIN, RST_EXP_FLOWS);
		repeat (MAX_FLOWS + 6)
			send_event(CMD_DATA, ID_W'($urandom), CNT_W'($urandom_range(0, 60000)));
		// known flows still count while the table is full
		send_event(CMD_DATA, tbl_flow[MAX_FLOWS - 1], 32'd1000);
		repeat (3) send_event(CMD_CLOSE, pick_close_target(), CNT_W'($urandom));
		repeat (4) send_event(CMD_DATA, ID_W'($urandom), CNT_W'($urandom));
		for (i = 0; i < MAX_FLOWS; i++)
			if (tbl_live[i])
				live_ids.insert(live_ids.size(), tbl_flow[i]);
		foreach (live_ids[k])
			send_event(CMD_CLOSE, live_ids[k], CNT_W'($urandom));
		wait_drained();
	endtask

	task automatic test_backpressure();
		// receiver holds off while beats keep coming, so the input stalls
		hold_req <= 1'b1;
		repeat (12)
			send_event(CMD_DATA, flow_pool[$urandom_range(0, POOL_SIZE - 1)],
				CNT_W'($urandom_range(0, 3000)));
		wait_drained();
	endtask

	task automatic test_random();
		int phase;
		int n;
		int roll;
		logic [CNT_W-1:0] nb;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
			0: apply_config(RST_IMB_THRESH, RST_NEAR_MARGIN, RST_THR_WIN, RST_FULL_WIN, 16'd3);
			1: apply_config(32'd0, 32'd0, 16'h0000, 16'hFFFF, 16'd1);
			2: apply_config(CNT_MAX, CNT_MAX, 16'hFFFF, 16'h0000, CLS_MAX);
			3: apply_config(CNT_W'($urandom_range(0, 20000)), CNT_W'($urandom_range(0, 10000)),
				WIN_W'($urandom), WIN_W'($urandom), CLS_W'($urandom_range(0, 6)));
			default: apply_config(CNT_W'($urandom), CNT_W'($urandom), WIN_W'($urandom),
				WIN_W'($urandom), CLS_W'($urandom_range(0, 4)));
			endcase
			for (n = 0; n < PHASE_BEATS; n++) begin
				roll = $urandom_range(0, 99);
				if ($urandom_range(0, 19) == 0)
					nb = CNT_W'($urandom);
				else
					nb = CNT_W'($urandom_range(0, 4000));
				if (roll < 65)
					send_event(CMD_DATA, flow_pool[$urandom_range(0, POOL_SIZE - 1)], nb);
				else if (roll < 77)
					send_event(CMD_DATA, ID_W'($urandom), nb);
				else if (roll < 89)
					send_event(CMD_CLOSE, pick_close_target(), CNT_W'($urandom));
				else if (roll < 95)
					send_event(CMD_START, ID_W'($urandom), CNT_W'($urandom));
				else
					send_event(CMD_UNUSED, ID_W'($urandom), CNT_W'($urandom));
			end
			wait_drained();
		end
	endtask

	always @(posedge clk) begin : hold_timer
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : result_sink
		decision_t got;
		decision_t want;
		int draw;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got = {window_valid, window_limit, round_done, table_full};
				if (pending_decisions.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result valid/limit/done/full %0d/%0d/%0d/%0d",
							$realtime, got.window_valid, got.window_limit, got.round_done,
							got.table_full);
				end else begin
					want = pending_decisions[0];
					pending_decisions.delete(0);
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime, want.window_valid, want.window_limit,
								want.round_done, want.table_full, got.window_valid,
								got.window_limit, got.round_done, got.table_full);
					end
				end
				draw = $urandom_range(0, 9);
				stall_left <= draw;
				rand_stall <= (draw != 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rand_stall <= (stall_left > 1);
			end
		end
	end

	initial begin : run
		int i;
		foreach (flow_pool[k])
			flow_pool[k] = ID_W'($urandom);
		cfg_m.imb_thresh = RST_IMB_THRESH;
		cfg_m.near_margin = RST_NEAR_MARGIN;
		cfg_m.thr_win = RST_THR_WIN;
		cfg_m.full_win = RST_FULL_WIN;
		cfg_m.exp_flows = RST_EXP_FLOWS;
		for (i = 0; i < MAX_FLOWS; i++)
			tbl_live[i] = 1'b0;
		closes_m = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_decisions.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/fwt_pkg.sv
design/fwt_cfg.sv
design/fwt_ctrl.sv
design/fwt_dp.sv
design/flow_fairness_window_throttle.sv
design/fwt_checker.sv
tb/sv/flow_fairness_window_throttle_tb.sv
